// File: rtl/core/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants shared by the meter frame receiver modules.
// ----------------------------------------------------------------------------
package mfr_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'h68;
	localparam logic [7:0] SCRAMBLE   = 8'h33;
	localparam logic [2:0] LAST_ADDR  = 3'd5;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_SYNC2 = 3'd2,
		PH_CTRL  = 3'd3,
		PH_LEN   = 3'd4,
		PH_DATA  = 3'd5,
		PH_SUM   = 3'd6,
		PH_END   = 3'd7
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPTED = 2'd0,
		VERDICT_ADDRESS  = 2'd1,
		VERDICT_CHECKSUM = 2'd2,
		VERDICT_HEADER   = 2'd3
	} verdict_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		verdict_t   verdict;
		logic [7:0] control_code;
		logic [7:0] payload_length;
	} result_t;

endpackage

// File: rtl/core/mfr_parse.sv
// ----------------------------------------------------------------------------
// mfr_parse
// Frame parser: walks the frame layout one byte at a time and produces at most
// one result per byte.
// ----------------------------------------------------------------------------
module mfr_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      rx_byte,
	input  logic [47:0]     station_address,
	output logic            res_valid,
	output mfr_pkg::result_t res
);
	import mfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] sum_q, sum_d;
	logic       addr_ok_q, addr_ok_d;
	logic [7:0] len_q, len_d;
	logic [7:0] ctrl_q, ctrl_d;
	logic       sum_ok_q, sum_ok_d;
	logic [7:0] want;
	logic [7:0] sum_add;
	logic [8:0] pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			pos_q     <= '0;
			sum_q     <= '0;
			addr_ok_q <= 1'b1;
			len_q     <= '0;
			ctrl_q    <= '0;
			sum_ok_q  <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			addr_ok_q <= addr_ok_d;
			len_q     <= len_d;
			ctrl_q    <= ctrl_d;
			sum_ok_q  <= sum_ok_d;
		end
	end

	// Expected address byte for the current address position.
	always_comb begin
		case (pos_q[2:0])
			3'd1:    want = station_address[15:8];
			3'd2:    want = station_address[23:16];
			3'd3:    want = station_address[31:24];
			3'd4:    want = station_address[39:32];
			3'd5:    want = station_address[47:40];
			default: want = station_address[7:0];
		endcase
	end

	assign sum_add = sum_q + rx_byte;
	assign pos_inc = {1'b0, pos_q} + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		addr_ok_d = addr_ok_q;
		len_d     = len_q;
		ctrl_d    = ctrl_q;
		sum_ok_d  = sum_ok_q;
		res_valid = 1'b0;
		res       = '0;
		if (advance) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == SYNC_BYTE) begin
						sum_d     = rx_byte;
						pos_d     = '0;
						addr_ok_d = 1'b1;
						sum_ok_d  = 1'b0;
						phase_d   = PH_ADDR;
					end
				end
				PH_ADDR: begin
					if (rx_byte != want) begin
						addr_ok_d = 1'b0;
					end
					sum_d = sum_add;
					pos_d = pos_inc[7:0];
					if (pos_q[2:0] == LAST_ADDR) begin
						phase_d = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (rx_byte != SYNC_BYTE) begin
						phase_d     = PH_HUNT;
						res_valid   = 1'b1;
						res.kind    = KIND_VERDICT;
						res.verdict = VERDICT_HEADER;
					end else begin
						sum_d   = sum_add;
						phase_d = PH_CTRL;
					end
				end
				PH_CTRL: begin
					ctrl_d  = rx_byte;
					sum_d   = sum_add;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d   = rx_byte;
					sum_d   = sum_add;
					pos_d   = '0;
					phase_d = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
				end
				PH_DATA: begin
					sum_d = sum_add;
					pos_d = pos_inc[7:0];
					if (pos_inc >= {1'b0, len_q}) begin
						phase_d = PH_SUM;
					end
					res_valid          = 1'b1;
					res.kind           = KIND_PAYLOAD;
					res.payload_byte   = rx_byte - SCRAMBLE;
					res.control_code   = ctrl_q;
					res.payload_length = len_q;
				end
				PH_SUM: begin
					sum_ok_d = (rx_byte == sum_q);
					phase_d  = PH_END;
				end
				PH_END: begin
					phase_d            = PH_HUNT;
					res_valid          = 1'b1;
					res.kind           = KIND_VERDICT;
					res.control_code   = ctrl_q;
					res.payload_length = len_q;
					if (!addr_ok_q) begin
						res.verdict = VERDICT_ADDRESS;
					end else if (!sum_ok_q) begin
						res.verdict = VERDICT_CHECKSUM;
					end else begin
						res.verdict = VERDICT_ACCEPTED;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	a_addr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ADDR |-> pos_q < 8'd6)
		else $error("address position out of range");

	a_verdict_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_VERDICT |-> res.payload_byte == 8'd0)
		else $error("verdict carries a payload byte");

	a_data_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> pos_q < len_q)
		else $error("data position passed the frame length");

endmodule

// File: rtl/core/mfr_out_buf.sv
// ----------------------------------------------------------------------------
// mfr_out_buf
// Two-entry result buffer: an output register backed by a skid register, so
// a stalled receiver does not stop the parser at once.
// ----------------------------------------------------------------------------
module mfr_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfr_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output mfr_pkg::result_t out_data
);
	import mfr_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into a full buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q && out_valid_q)
		else $error("skid entry did not move to the output register");

endmodule

// File: rtl/core/meter_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// meter_frame_receiver_unit
// Receives meter-link bytes, checks frame header, address and checksum,
// and delivers descrambled payload beats and one verdict beat per frame.
// ----------------------------------------------------------------------------
// Usage:
// The receive channel (rx_valid, rx_stall, rx_byte) takes one byte per beat.
// The result channel (out_valid, out_stall and the field ports) delivers a
// payload beat for every data byte of a frame and a verdict beat on the last
// byte of a frame, or on a bad second start byte.
// The configuration channel (cfg_valid, cfg_ready, station_address) writes
// the expected station address; it is always ready and is meant to be
// written while no frame is in flight.
// Throughput is one byte per cycle while the buffer is not full. A byte is
// captured in an input register at its beat and parsed from there once the
// buffer has room; its result is registered in the output buffer.
// When the receiver holds out_stall, results collect in a two-entry buffer;
// rx_stall rises only once the second entry is occupied, and drops as the
// waiting result moves forward into the output register.
// Reset clears the parser to hunting for a start byte, empties the buffer
// and the input register, and sets the station address to zero.
// ----------------------------------------------------------------------------
module meter_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  verdict,
	output logic [7:0]  control_code,
	output logic [7:0]  payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] station_address
);
	import mfr_pkg::*;

	logic [47:0] station_address_q;
	logic        byte_valid_s1;
	logic [7:0]  byte_s1;
	logic        buf_full;
	logic        advance;
	logic        res_valid;
	result_t     res;
	result_t     out_data;

	// The configuration port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			station_address_q <= station_address;
		end
	end

	// Input register. While the buffer is not full the held byte is parsed in
	// the same cycle a new one is captured, so the register never overflows.
	assign rx_stall = buf_full;
	assign advance  = byte_valid_s1 && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!buf_full) begin
			byte_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	mfr_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.rx_byte         (byte_s1),
		.station_address (station_address_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	mfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind           = out_data.kind;
	assign payload_byte   = out_data.payload_byte;
	assign verdict        = out_data.verdict;
	assign control_code   = out_data.control_code;
	assign payload_length = out_data.payload_length;

endmodule

// File: tb/mfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_frame_checker
// Watches the byte, result and address channels of the meter frame receiver,
// parses every accepted byte itself and compares each result beat with the
// oldest result it expects.
// ----------------------------------------------------------------------------
module mfr_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [7:0]  payload_byte,
	input  logic [1:0]  verdict,
	input  logic [7:0]  control_code,
	input  logic [7:0]  payload_length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [47:0] station_address,
	output int          mismatches,
	output int          outstanding
);
	import mfr_pkg::*;

	logic [47:0] expected_address;
	phase_t      parse_phase;
	logic [7:0]  parse_position;
	logic [7:0]  frame_sum;
	logic [7:0]  frame_control;
	logic [7:0]  frame_length;
	logic        address_match;
	logic        sum_match;
	result_t     expected_results[$];

	task automatic push_result(kind_t k, logic [7:0] pb, verdict_t v, logic [7:0] cc,
			logic [7:0] pl);
		result_t r;
		r.kind = k;
		r.payload_byte = pb;
		r.verdict = v;
		r.control_code = cc;
		r.payload_length = pl;
		expected_results.push_back(r);
	endtask

	// Advances the frame parser by one received byte.
	task automatic parse_byte(logic [7:0] b);
		logic [7:0] want;
		case (parse_phase)
			PH_HUNT: begin
				if (b == SYNC_BYTE) begin
					frame_sum = b;
					parse_position = '0;
					address_match = 1'b1;
					sum_match = 1'b0;
					parse_phase = PH_ADDR;
				end
			end
			PH_ADDR: begin
				want = expected_address[8 * (parse_position % 6) +: 8];
				if (b != want)
					address_match = 1'b0;
				frame_sum += b;
				parse_position++;
				if (parse_position >= 6)
					parse_phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (b != SYNC_BYTE) begin
					parse_phase = PH_HUNT;
					push_result(KIND_VERDICT, '0, VERDICT_HEADER, '0, '0);
				end else begin
					frame_sum += b;
					parse_phase = PH_CTRL;
				end
			end
			PH_CTRL: begin
				frame_control = b;
				frame_sum += b;
				parse_phase = PH_LEN;
			end
			PH_LEN: begin
				frame_length = b;
				frame_sum += b;
				parse_position = '0;
				parse_phase = (b == 0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				frame_sum += b;
				parse_position++;
				if (parse_position >= frame_length)
					parse_phase = PH_SUM;
				push_result(KIND_PAYLOAD, b - SCRAMBLE, VERDICT_ACCEPTED, frame_control,
					frame_length);
			end
			PH_SUM: begin
				sum_match = (b == frame_sum);
				parse_phase = PH_END;
			end
			default: begin
				parse_phase = PH_HUNT;
				if (!address_match)
					push_result(KIND_VERDICT, '0, VERDICT_ADDRESS, frame_control, frame_length);
				else if (!sum_match)
					push_result(KIND_VERDICT, '0, VERDICT_CHECKSUM, frame_control, frame_length);
				else
					push_result(KIND_VERDICT, '0, VERDICT_ACCEPTED, frame_control, frame_length);
			end
		endcase
	endtask

	task automatic flag_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t head;
		if (!arst_n) begin
			expected_address = '0;
			parse_phase = PH_HUNT;
			parse_position = '0;
			frame_sum = '0;
			frame_control = '0;
			frame_length = '0;
			address_match = 1'b1;
			sum_match = 1'b0;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				expected_address = station_address;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, actual kind %0d byte %0d verdict %0d",
						$time, kind, payload_byte, verdict);
				end else begin
					head = expected_results.pop_front();
					flag_field("kind", head.kind, kind);
					flag_field("payload_byte", head.payload_byte, payload_byte);
					flag_field("verdict", head.verdict, verdict);
					flag_field("control_code", head.control_code, control_code);
					flag_field("payload_length", head.payload_length, payload_length);
				end
			end
			if (rx_valid && !rx_stall)
				parse_byte(rx_byte);
			outstanding = expected_results.size();
		end
	end

endmodule

// File: tb/tb_meter_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_meter_frame_receiver_unit
// Feeds meter-link frames, broken frames and line noise into the frame
// receiver under random stalls on both channels, and across several station
// addresses. A checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_meter_frame_receiver_unit;
	import mfr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [1:0]  verdict;
	logic [7:0]  control_code;
	logic [7:0]  payload_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [47:0] station_address = '0;
	int          mismatches;
	int          outstanding;

	// When quiet is set, neither side inserts idle cycles. A bump of
	// hold_requests makes the result side hold off for one long stretch.
	bit quiet = 1'b0;
	int hold_requests = 0;
	// Bytes sent as part of frames; line noise is not counted.
	int frame_bytes = 0;

	meter_frame_receiver_unit dut (.*);

	mfr_frame_checker frame_check (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The run should end long before this. Hitting it means the block hung.
	initial begin
		#10_000_000;
		$display("tb_meter_frame_receiver_unit failed");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Offers one byte and returns at the edge where it is taken. The handshake
	// is sampled on the falling edge, where rx_stall is settled, so the result
	// does not depend on event order at the rising edge. Valid stays high on
	// return so back-to-back beats need no toggle.
	task automatic send_byte(logic [7:0] b);
		int gap;
		bit taken;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			taken = !rx_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sends one frame. The address goes out lowest byte first. A broken frame
	// either carries a wrong second start byte, which ends it right there, or
	// a corrupted checksum.
	task automatic send_frame(logic [47:0] addr, logic [7:0] ctrl, logic [7:0] len,
			bit bad_sync, bit bad_sum, logic [7:0] last);
		logic [7:0] sum;
		logic [7:0] b;
		sum = SYNC_BYTE;
		send_byte(SYNC_BYTE);
		for (int i = 0; i < 6; i++) begin
			b = addr[8 * i +: 8];
			sum += b;
			send_byte(b);
		end
		if (bad_sync) begin
			b = 8'($urandom_range(0, 255));
			if (b == SYNC_BYTE)
				b = ~b;
			send_byte(b);
			frame_bytes += 8;
			return;
		end
		send_byte(SYNC_BYTE);
		sum += SYNC_BYTE;
		send_byte(ctrl);
		sum += ctrl;
		send_byte(len);
		sum += len;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			sum += b;
			send_byte(b);
		end
		send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
		send_byte(last);
		frame_bytes += 12 + len;
	endtask

	// One random chunk of traffic: mostly well-formed frames with random
	// content, the rest wrong addresses, bad second start bytes, bad
	// checksums and bursts of line noise between frames.
	task automatic random_frame(logic [47:0] addr);
		int r;
		int k;
		int len;
		logic [47:0] a;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		a = addr;
		if (r < 18) begin
			k = $urandom_range(0, 5);
			a[8 * k +: 8] ^= 8'($urandom_range(1, 255));
		end
		len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 60);
		send_frame(a, 8'($urandom_range(0, 255)), 8'(len), r >= 18 && r < 24,
			r >= 24 && r < 34, 8'($urandom_range(0, 255)));
	endtask

	task automatic write_station(logic [47:0] addr);
		bit taken;
		cfg_valid <= 1'b1;
		station_address <= addr;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	// Lets every expected beat come out, then waits on so that bytes without a
	// result have passed the two-stage pipeline and been parsed too.
	task automatic drain();
		rx_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Result side. Stalls come in random stretches, none at all while quiet,
	// and one long hold when asked, so that the output buffer fills and the
	// block pushes back on its byte input.
	initial begin : result_side
		int n;
		int served;
		served = 0;
		@(posedge clk);
		forever begin
			if (hold_requests != served) begin
				served = hold_requests;
				n = 300;
			end else begin
				n = quiet ? 0 : pick_gap();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin : byte_side
		logic [47:0] addr;
		int stop_at;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames first.
		addr = 48'h1234_5678_9ABC;
		write_station(addr);
		// A good frame with no payload: the checksum follows the length byte.
		send_frame(addr, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00);
		send_frame(addr, 8'hFF, 8'd2, 1'b0, 1'b0, 8'hFF);
		// Wrong address and wrong checksum together must report the address.
		send_frame(addr ^ 48'h1, 8'h91, 8'd1, 1'b0, 1'b1, 8'h16);
		send_frame(addr, 8'h11, 8'd1, 1'b0, 1'b1, 8'h16);
		// A wrong second start byte gives a header error and back to hunting.
		send_frame(addr, 8'h11, 8'd0, 1'b1, 1'b0, 8'h00);
		send_byte(8'h00);
		// A final byte equal to the start byte must not open a new frame.
		send_frame(addr, 8'h91, 8'd1, 1'b0, 1'b0, SYNC_BYTE);
		send_byte(8'h00);
		drain();

		// Random phases, each with its own station address. The first two are
		// the extremes, the third is full of start bytes, one phase runs with
		// no idling at all, and one starts with a maximum-length frame under a
		// long hold on the result side.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: addr = '0;
				1: addr = '1;
				2: addr = 48'h6868_6868_6868;
				default: addr = {16'($urandom), 32'($urandom)};
			endcase
			quiet = (p == 3);
			write_station(addr);
			if (p == 1) begin
				hold_requests++;
				send_frame(addr, 8'h91, 8'd255, 1'b0, 1'b0, 8'h16);
			end
			stop_at = frame_bytes + 240;
			while (frame_bytes < stop_at)
				random_frame(addr);
			drain();
		end

		if (mismatches == 0)
			$display("tb_meter_frame_receiver_unit passed");
		else
			$display("tb_meter_frame_receiver_unit failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/mfr_pkg.sv
rtl/core/mfr_parse.sv
rtl/core/mfr_out_buf.sv
rtl/core/meter_frame_receiver_unit.sv
tb/mfr_frame_checker.sv
tb/tb_meter_frame_receiver_unit.sv
